/* design/pad_pkg.sv */
package pad_pkg;

  // Field widths of the stream items.
  localparam int AdcW   = 8;
  localparam int LevelW = 12;
  localparam int CountW = 8;

  // The converter byte is scaled up by this shift to form a sample.
  localparam int SampleShift = 4;
  localparam int SampleScale = 1 << SampleShift;

  // An average closes once AvgThreshold+1 peaks have been summed.
  localparam int AvgThreshold = 80;
  localparam int AvgCount     = AvgThreshold + 1;

  // The running sum is kept as quotient and remainder of the peak count.
  localparam int RemW  = $clog2(AvgCount);
  localparam int QuotW = LevelW;

  localparam logic [LevelW-1:0] DeadbandReset = LevelW'(6);

  // Per-code quotient and remainder of a scaled peak divided by the peak count.
  typedef logic [QuotW-1:0] quot_tab_t [1 << AdcW];
  typedef logic [RemW-1:0]  rem_tab_t  [1 << AdcW];

  function automatic quot_tab_t build_quot_tab();
    quot_tab_t tab;
    for (int i = 0; i < (1 << AdcW); i++) begin
      tab[i] = QuotW'((i * SampleScale) / AvgCount);
    end
    return tab;
  endfunction

  function automatic rem_tab_t build_rem_tab();
    rem_tab_t tab;
    for (int i = 0; i < (1 << AdcW); i++) begin
      tab[i] = RemW'((i * SampleScale) % AvgCount);
    end
    return tab;
  endfunction

  localparam quot_tab_t QuotTab = build_quot_tab();
  localparam rem_tab_t  RemTab  = build_rem_tab();

  // One item held in the input register.
  typedef struct packed {
    logic            valid;
    logic [AdcW-1:0] adc;
  } pad_item_t;

endpackage

/* design/pad_in_stage.sv */
module pad_in_stage (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [7:0]              s_tdata,   // [7:0] adc_high
  input  logic                    take,
  output pad_pkg::pad_item_t      item
);
  import pad_pkg::*;

  // The register is free when empty or when its beat moves on this cycle.
  assign s_tready = !item.valid || take;

  // Input register: holds one beat until the core takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (s_tready) begin
      item.valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      item.adc <= s_tdata[AdcW-1:0];
    end
  end

endmodule

/* design/pad_core.sv */
module pad_core (
  input  logic                         clk,
  input  logic                         rst,
  input  pad_pkg::pad_item_t           item,
  output logic                         take,
  input  logic [pad_pkg::LevelW-1:0]   deadband,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pad_pkg::LevelW-1:0]   level,
  output logic                         peak_captured,
  output logic                         average_done
);
  import pad_pkg::*;

  // Meter state. The peak is kept as its converter code; the sum of peaks
  // is kept as quotient and remainder of the peak count.
  logic [AdcW-1:0]   peak_code;
  logic              armed;
  logic [QuotW-1:0]  sum_quot;
  logic [RemW-1:0]   sum_rem;
  logic [CountW-1:0] peak_count;
  logic [LevelW-1:0] held_level;

  logic [AdcW-1:0]   peak_code_next;
  logic              armed_next;
  logic [QuotW-1:0]  sum_quot_next;
  logic [RemW-1:0]   sum_rem_next;
  logic [CountW-1:0] peak_count_next;
  logic [LevelW-1:0] held_level_next;
  logic              captured;
  logic              done;

  logic [RemW:0]     rem_add;
  logic              rem_carry;
  logic [QuotW-1:0]  quot_add;
  logic [LevelW:0]   level_dist;

  // A beat moves into the result register when that register is free.
  assign take = item.valid && (!out_valid || out_ready);

  // Peak tracking, half-wave capture and the average with its deadband.
  always_comb begin
    peak_code_next  = peak_code;
    armed_next      = armed;
    sum_quot_next   = sum_quot;
    sum_rem_next    = sum_rem;
    peak_count_next = peak_count;
    held_level_next = held_level;
    captured        = 1'b0;
    done            = 1'b0;

    rem_add    = {1'b0, sum_rem} + {1'b0, RemTab[peak_code]};
    rem_carry  = (rem_add >= (RemW + 1)'(AvgCount));
    // Quotient of the sum after a capture; at the close this is the average.
    quot_add   = sum_quot + QuotTab[peak_code] + QuotW'(rem_carry);
    level_dist = '0;

    if (peak_code < item.adc) begin
      peak_code_next = item.adc;
      armed_next     = 1'b1;
    end else if ((item.adc == '0) && armed) begin
      armed_next      = 1'b0;
      captured        = 1'b1;
      peak_code_next  = '0;
      sum_rem_next    = rem_carry ? RemW'(rem_add - (RemW + 1)'(AvgCount))
                                  : rem_add[RemW-1:0];
      sum_quot_next   = quot_add;
      peak_count_next = peak_count + CountW'(1);
    end

    // The count steps by one, so the average closes exactly at AvgCount.
    if (captured && (peak_count_next == CountW'(AvgCount))) begin
      done            = 1'b1;
      sum_quot_next   = '0;
      sum_rem_next    = '0;
      peak_count_next = '0;
      level_dist = (quot_add > held_level)
                   ? ({1'b0, quot_add} - {1'b0, held_level})
                   : ({1'b0, held_level} - {1'b0, quot_add});
      if (!(level_dist < {1'b0, deadband})) begin
        held_level_next = quot_add;
      end
    end
  end

  // State update on each beat taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_code  <= '0;
      armed      <= 1'b0;
      sum_quot   <= '0;
      sum_rem    <= '0;
      peak_count <= '0;
      held_level <= '0;
    end else if (take) begin
      peak_code  <= peak_code_next;
      armed      <= armed_next;
      sum_quot   <= sum_quot_next;
      sum_rem    <= sum_rem_next;
      peak_count <= peak_count_next;
      held_level <= held_level_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (take) begin
      level         <= held_level_next;
      peak_captured <= captured;
      average_done  <= done;
    end
  end

endmodule

/* design/peak_average_deadband_meter_top.sv */
// Channel   Dir  Width  Contents
// s_*       in   8      tdata: adc_high [7:0]
// m_*       out  16     tdata: level [11:0], peak_captured [12], average_done [13]
// cfg_*     in   12     deadband register, written when cfg_wr_en is high
//
// Each accepted beat is held in the input register and then moves to the
// result register, where m_tvalid shows its result; while the output does not
// stall, one beat is accepted every cycle. The whole update of the
// meter state sits between those two registers. Reset is synchronous and
// clears the state and sets the deadband to 6. When the output stalls, one
// more beat is held in the input register before s_tready drops.
module peak_average_deadband_meter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [7:0] adc_high
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // [11:0] level, [12] peak_captured,
                                    // [13] average_done, [15:14] zero
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data
);
  import pad_pkg::*;

  logic [LevelW-1:0] deadband;
  pad_item_t         item;
  logic              take;
  logic [LevelW-1:0] level;
  logic              peak_captured;
  logic              average_done;

  // Deadband register.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadband <= DeadbandReset;
    end else if (cfg_wr_en) begin
      deadband <= cfg_wr_data[LevelW-1:0];
    end
  end

  pad_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .item     (item)
  );

  pad_core u_core (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .take          (take),
    .deadband      (deadband),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .level         (level),
    .peak_captured (peak_captured),
    .average_done  (average_done)
  );

  // Result beat packing.
  assign m_tdata = {2'b00, average_done, peak_captured, level};

endmodule

/* design/pad_checker.sv */
module pad_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        cfg_wr_en,
  input logic [11:0] cfg_wr_data
);

  // An average only closes on the beat that captures a peak.
  a_done_needs_capture: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[13]) |-> m_tdata[12])
    else $error("average_done without peak_captured");

  // The level is an average of samples, so it never exceeds 4080.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:0] <= 12'd4080) && (m_tdata[15:14] == 2'b00))
    else $error("level out of range or padding set");

  // The input side only stalls while a result waits at the output.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

  // A stalled result holds its beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind peak_average_deadband_meter_top pad_checker u_pad_checker (.*);
